// ===== rtl/mcw_pkg.sv =====
// mcw_pkg: shared types and constants of the multi-channel watchdog.
// No dependencies; imported by mcw_sub and multi_channel_watchdog.
`default_nettype none
package mcw_pkg;

   localparam int MCW_ENTRIES = 8;
   localparam int ID_W        = 8;
   localparam int TIME_W      = 32;
   localparam int CSR_IDX_W   = 1;
   localparam logic [TIME_W-1:0] GTIMEOUT_RESET = 32'd5000;

   // request opcodes
   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_KICK     = 2'd1;
   localparam logic [1:0] OP_CHECK    = 2'd2;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GTIMEOUT = 1'd1;

   typedef enum logic [2:0] {
      KIND_REGISTERED,
      KIND_FULL,
      KIND_KICK,
      KIND_TIMEOUT,
      KIND_SUMMARY
   } kind_type;

   // operand selection for the shared subtractor
   typedef enum logic [1:0] {
      SUB_ELAPSED,   // now - last_kick
      SUB_ALIVE,     // timeout - elapsed, borrow means expired
      SUB_LEAST      // elapsed - least, borrow means new minimum
   } sub_sel_type;

   typedef struct packed {
      sub_sel_type       sel;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] last_kick;
      logic [TIME_W-1:0] timeout;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] least;
   } sub_req_type;

endpackage
`default_nettype wire

// ===== rtl/multi_channel_watchdog.sv =====
// multi_channel_watchdog: client table, sequencer and result register.
// Depends on mcw_pkg, mcw_ram and mcw_sub.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, client_id, client_timeout, time_stamp
//   rsp      out        rsp_valid / rsp_stall  kind, id, matched, duration, expired, least, last
//   csr      in         csr_valid / csr_ready  index, wdata
//
// Register: ST_REG writes the table unless full, then ST_ONE loads the result register. Kick:
// each entry searched passes ST_KRD and ST_KCMP. Check: each entry passes ST_CRD, then the one
// shared subtractor (elapsed, alive test, minimum); ST_CREP reports a timeout, ST_SUM sums up.
// req_stall is high from acceptance until the last result is in the output register.
// The output register keeps its result while rsp_stall is high; the sequencer waits.
// Synchronous reset clears the table count, the enable and the handshakes, and loads GTIMEOUT_RESET.
`default_nettype none
module multi_channel_watchdog import mcw_pkg::*; #(
   parameter int ENTRIES = MCW_ENTRIES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [ID_W-1:0]      req_client_id,
   input  wire logic [TIME_W-1:0]    req_client_timeout,
   input  wire logic [TIME_W-1:0]    req_time_stamp,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_result_kind,
   output logic [ID_W-1:0]           rsp_reported_id,
   output logic                      rsp_kick_matched,
   output logic [TIME_W-1:0]         rsp_timeout_duration,
   output logic                      rsp_all_expired,
   output logic [TIME_W-1:0]         rsp_least_elapsed,
   output logic                      rsp_last_result,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_REG, ST_KRD, ST_KCMP, ST_CRD, ST_CEL, ST_CTO, ST_CLS,
      ST_CREP, ST_SUM, ST_ONE
   } state_type;

   // control registers
   logic              enabled_ff;
   logic [TIME_W-1:0] gtimeout_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         gtimeout_ff <= GTIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:   enabled_ff  <= csr_wdata[0];
            CSR_GTIMEOUT: gtimeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] tmo_ff, tmo_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] el_ff, el_in;
   logic [TIME_W-1:0] least_ff, least_in;
   logic              found_ff, found_in;
   logic              alive_ff, alive_in;
   logic              over_ff, over_in;
   kind_type          kind_ff, kind_in;
   logic              matched_ff, matched_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_matched_ff, rsp_matched_in;
   logic [TIME_W-1:0] rsp_dur_ff, rsp_dur_in;
   logic              rsp_expired_ff, rsp_expired_in;
   logic [TIME_W-1:0] rsp_least_ff, rsp_least_in;
   logic              rsp_last_ff, rsp_last_in;

   // table memories
   logic                     ent_we;
   logic                     lk_we;
   logic [IDX_W-1:0]         wr_addr;
   logic [ID_W+TIME_W-1:0]   ent_rd;
   logic [TIME_W-1:0]        lk_rd;
   logic [ID_W-1:0]          rd_id;
   logic [TIME_W-1:0]        rd_tmo;

   mcw_ram #(.WIDTH(ID_W + TIME_W), .DEPTH(ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (wr_addr),
      .wr_data ({id_ff, tmo_ff}),
      .rd_addr (idx_ff),
      .rd_data (ent_rd)
   );

   mcw_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_lk_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (wr_addr),
      .wr_data (now_ff),
      .rd_addr (idx_ff),
      .rd_data (lk_rd)
   );

   assign rd_id  = ent_rd[ID_W+TIME_W-1:TIME_W];
   assign rd_tmo = ent_rd[TIME_W-1:0];

   // shared subtractor
   sub_req_type       sub_req;
   logic [TIME_W-1:0] sub_diff;
   logic              sub_borrow;

   mcw_sub u_sub (
      .req    (sub_req),
      .diff   (sub_diff),
      .borrow (sub_borrow)
   );

   logic              slot_free;
   logic              full;
   logic              last_entry;
   logic [CNT_W-1:0]  idx_next_ext;

   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign full         = (cnt_ff == CNT_W'(ENTRIES));
   assign idx_next_ext = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_entry   = (idx_next_ext == cnt_ff);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      id_in          = id_ff;
      tmo_in         = tmo_ff;
      now_in         = now_ff;
      el_in          = el_ff;
      least_in       = least_ff;
      found_in       = found_ff;
      alive_in       = alive_ff;
      over_in        = over_ff;
      kind_in        = kind_ff;
      matched_in     = matched_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_dur_in     = rsp_dur_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_least_in   = rsp_least_ff;
      rsp_last_in    = rsp_last_ff;
      ent_we         = 1'b0;
      lk_we          = 1'b0;
      wr_addr        = idx_ff;
      sub_req        = '{sel: SUB_ELAPSED, now: now_ff, last_kick: lk_rd,
                         timeout: rd_tmo, elapsed: el_ff, least: least_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in    = req_client_id;
               tmo_in   = req_client_timeout;
               now_in   = req_time_stamp;
               idx_in   = '0;
               found_in = 1'b0;
               alive_in = 1'b0;
               least_in = '0;
               unique case (req_opcode)
                  OP_REGISTER: state_in = ST_REG;
                  OP_KICK: begin
                     kind_in    = KIND_KICK;
                     matched_in = 1'b0;
                     state_in   = (enabled_ff && cnt_ff != '0) ? ST_KRD : ST_ONE;
                  end
                  OP_CHECK: state_in = (cnt_ff == '0) ? ST_SUM : ST_CRD;
                  default: ;
               endcase
            end
         end
         ST_REG: begin
            matched_in = 1'b0;
            if (full) begin
               kind_in = KIND_FULL;
            end else begin
               kind_in = KIND_REGISTERED;
               ent_we  = 1'b1;
               lk_we   = 1'b1;
               wr_addr = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            state_in = ST_ONE;
         end
         ST_KRD: state_in = ST_KCMP;
         ST_KCMP: begin
            if (rd_id == id_ff) begin
               lk_we      = 1'b1;
               matched_in = 1'b1;
               state_in   = ST_ONE;
            end else if (last_entry) begin
               state_in = ST_ONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_KRD;
            end
         end
         ST_CRD: state_in = ST_CEL;
         ST_CEL: begin
            sub_req.sel = SUB_ELAPSED;
            el_in       = sub_diff;
            state_in    = ST_CTO;
         end
         ST_CTO: begin
            sub_req.sel = SUB_ALIVE;
            over_in     = sub_borrow;
            if (!sub_borrow) begin
               alive_in = 1'b1;
            end
            state_in = ST_CLS;
         end
         ST_CLS: begin
            sub_req.sel = SUB_LEAST;
            if (!found_ff || sub_borrow) begin
               least_in = el_ff;
               found_in = 1'b1;
            end
            if (enabled_ff && over_ff) begin
               state_in = ST_CREP;
            end else if (last_entry) begin
               state_in = ST_SUM;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_CRD;
            end
         end
         ST_CREP: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_TIMEOUT;
               rsp_id_in      = rd_id;
               rsp_matched_in = 1'b0;
               rsp_dur_in     = gtimeout_ff;
               rsp_expired_in = 1'b0;
               rsp_least_in   = '0;
               rsp_last_in    = 1'b0;
               if (last_entry) begin
                  state_in = ST_SUM;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_CRD;
               end
            end
         end
         ST_SUM: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_SUMMARY;
               rsp_id_in      = '0;
               rsp_matched_in = 1'b0;
               rsp_dur_in     = '0;
               rsp_expired_in = !alive_ff;
               rsp_least_in   = found_ff ? least_ff : '0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = kind_ff;
               rsp_id_in      = id_ff;
               rsp_matched_in = matched_ff;
               rsp_dur_in     = '0;
               rsp_expired_in = 1'b0;
               rsp_least_in   = '0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      id_ff          <= id_in;
      tmo_ff         <= tmo_in;
      now_ff         <= now_in;
      el_ff          <= el_in;
      least_ff       <= least_in;
      found_ff       <= found_in;
      alive_ff       <= alive_in;
      over_ff        <= over_in;
      kind_ff        <= kind_in;
      matched_ff     <= matched_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_dur_ff     <= rsp_dur_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_least_ff   <= rsp_least_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_kind_ff;
   assign rsp_reported_id      = rsp_id_ff;
   assign rsp_kick_matched     = rsp_matched_ff;
   assign rsp_timeout_duration = rsp_dur_ff;
   assign rsp_all_expired      = rsp_expired_ff;
   assign rsp_least_elapsed    = rsp_least_ff;
   assign rsp_last_result      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ENTRIES))
      else $error("client count beyond table size");

   a_reg_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REG && !full) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("register did not grow the table");

   a_report_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_TIMEOUT) |-> enabled_ff)
      else $error("timeout report while disabled");

   a_match_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_KICK && rsp_kick_matched) |-> enabled_ff)
      else $error("kick matched while disabled");

   a_idx_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KCMP || state_ff == ST_CLS) |-> (CNT_W'(idx_ff) < cnt_ff))
      else $error("walk index beyond client count");
`endif

endmodule
`default_nettype wire

// ===== rtl/mcw_ram.sv =====
// mcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/mcw_sub.sv =====
// mcw_sub: shared 32-bit subtractor with borrow, used for elapsed time,
// timeout test and minimum search. Depends on mcw_pkg.
`default_nettype none
module mcw_sub import mcw_pkg::*; (
   input  wire sub_req_type       req,
   output logic [TIME_W-1:0]      diff,
   output logic                   borrow
);

   logic [TIME_W-1:0] op_a;
   logic [TIME_W-1:0] op_b;
   logic [TIME_W:0]   full;

   always_comb begin
      unique case (req.sel)
         SUB_ELAPSED: begin
            op_a = req.now;
            op_b = req.last_kick;
         end
         SUB_ALIVE: begin
            op_a = req.timeout;
            op_b = req.elapsed;
         end
         SUB_LEAST: begin
            op_a = req.elapsed;
            op_b = req.least;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign full   = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = full[TIME_W-1:0];
   assign borrow = full[TIME_W];

endmodule
`default_nettype wire

// ===== bench/tb_multi_channel_watchdog.sv =====
`timescale 1ns / 1ps
// tb_multi_channel_watchdog: self-checking bench for the client watchdog table.
// Directed request table, then random kicks, checks and registrations under idling and a long hold-off.
// Depends on mcw_pkg and multi_channel_watchdog.
module tb_multi_channel_watchdog;
   import mcw_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ENTRIES      = MCW_ENTRIES;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ROUND_ITEMS  = 34;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic              matched;
      logic [TIME_W-1:0] dur;
      logic              expired;
      logic [TIME_W-1:0] least;
      logic              last;
   } wd_rsp_t;

   typedef struct {
      bit                is_csr;
      logic [TIME_W-1:0] csr_en;
      logic [TIME_W-1:0] csr_gto;
      logic [1:0]        op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] tmo;
      logic [TIME_W-1:0] now;
      bit                typed;
      wd_rsp_t           want;
   } step_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_opcode = '0;
   logic [ID_W-1:0]      req_client_id = '0;
   logic [TIME_W-1:0]    req_client_timeout = '0;
   logic [TIME_W-1:0]    req_time_stamp = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_result_kind;
   logic [ID_W-1:0]      rsp_reported_id;
   logic                 rsp_kick_matched;
   logic [TIME_W-1:0]    rsp_timeout_duration;
   logic                 rsp_all_expired;
   logic [TIME_W-1:0]    rsp_least_elapsed;
   logic                 rsp_last_result;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   // predictor copy of the client table and control registers
   logic [ID_W-1:0]   ent_id   [ENTRIES];
   logic [TIME_W-1:0] ent_kick [ENTRIES];
   logic [TIME_W-1:0] ent_tmo  [ENTRIES];
   bit                ent_on   [ENTRIES];
   int                ent_n = 0;
   bit                wd_on = 1'b0;
   logic [TIME_W-1:0] wd_gto = GTIMEOUT_RESET;

   wd_rsp_t step_rsp[$];
   wd_rsp_t awaited_rsp[$];
   step_t   directed_steps[$];

   int errors = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   multi_channel_watchdog dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_client_id        (req_client_id),
      .req_client_timeout   (req_client_timeout),
      .req_time_stamp       (req_time_stamp),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_reported_id      (rsp_reported_id),
      .rsp_kick_matched     (rsp_kick_matched),
      .rsp_timeout_duration (rsp_timeout_duration),
      .rsp_all_expired      (rsp_all_expired),
      .rsp_least_elapsed    (rsp_least_elapsed),
      .rsp_last_result      (rsp_last_result),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic wd_rsp_t mk_rsp(input kind_type kind, input logic [ID_W-1:0] id,
                                      input logic matched, input logic [TIME_W-1:0] dur,
                                      input logic expired, input logic [TIME_W-1:0] least,
                                      input logic last);
      wd_rsp_t r;
      r.kind    = kind;
      r.id      = id;
      r.matched = matched;
      r.dur     = dur;
      r.expired = expired;
      r.least   = least;
      r.last    = last;
      return r;
   endfunction

   function automatic step_t req(input logic [1:0] op, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] now);
      step_t s;
      s.is_csr  = 1'b0;
      s.csr_en  = '0;
      s.csr_gto = '0;
      s.op      = op;
      s.id      = id;
      s.tmo     = tmo;
      s.now     = now;
      s.typed   = 1'b0;
      s.want    = '0;
      return s;
   endfunction

   // request whose single result is typed in by hand
   function automatic step_t req_t(input logic [1:0] op, input logic [ID_W-1:0] id,
                                   input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] now,
                                   input kind_type kind, input logic [ID_W-1:0] rid,
                                   input logic matched, input logic expired,
                                   input logic [TIME_W-1:0] least);
      step_t s;
      s       = req(op, id, tmo, now);
      s.typed = 1'b1;
      s.want  = mk_rsp(kind, rid, matched, '0, expired, least, 1'b1);
      return s;
   endfunction

   function automatic step_t csr_step(input logic [TIME_W-1:0] en,
                                      input logic [TIME_W-1:0] gto);
      step_t s;
      s         = req(OP_UNUSED, '0, '0, '0);
      s.is_csr  = 1'b1;
      s.csr_en  = en;
      s.csr_gto = gto;
      return s;
   endfunction

   // expected results of one request, left in step_rsp; updates the table copy
   function automatic void predict_watchdog(input logic [1:0] op, input logic [ID_W-1:0] id,
                                            input logic [TIME_W-1:0] tmo,
                                            input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] el;
      logic [TIME_W-1:0] least;
      bit alive;
      bit found;
      bit hit;
      step_rsp.delete();
      least = '0;
      alive = 1'b0;
      found = 1'b0;
      hit   = 1'b0;
      case (op)
         OP_REGISTER: begin
            if (ent_n >= ENTRIES) begin
               step_rsp.push_back(mk_rsp(KIND_FULL, id, 1'b0, '0, 1'b0, '0, 1'b1));
            end else begin
               ent_id[ent_n]   = id;
               ent_kick[ent_n] = now;
               ent_tmo[ent_n]  = tmo;
               ent_on[ent_n]   = 1'b1;
               ent_n++;
               step_rsp.push_back(mk_rsp(KIND_REGISTERED, id, 1'b0, '0, 1'b0, '0, 1'b1));
            end
         end
         OP_KICK: begin
            if (wd_on) begin
               for (int i = 0; i < ent_n; i++) begin
                  if (!hit && ent_on[i] && ent_id[i] == id) begin
                     ent_kick[i] = now;
                     hit = 1'b1;
                  end
               end
            end
            step_rsp.push_back(mk_rsp(KIND_KICK, id, hit, '0, 1'b0, '0, 1'b1));
         end
         OP_CHECK: begin
            for (int i = 0; i < ent_n; i++) begin
               if (ent_on[i]) begin
                  el = now - ent_kick[i];
                  if (wd_on && el > ent_tmo[i])
                     step_rsp.push_back(mk_rsp(KIND_TIMEOUT, ent_id[i], 1'b0, wd_gto,
                                               1'b0, '0, 1'b0));
                  if (el <= ent_tmo[i])
                     alive = 1'b1;
                  if (!found || el < least) begin
                     least = el;
                     found = 1'b1;
                  end
               end
            end
            step_rsp.push_back(mk_rsp(KIND_SUMMARY, '0, 1'b0, '0, !alive, least, 1'b1));
         end
         default: ;
      endcase
   endfunction

   task automatic log_mismatch(input string msg);
      errors++;
      if (errors <= 50)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   // offer one request, hold it until taken, then perhaps leave a gap
   task automatic send_request(input step_t s);
      req_opcode         <= s.op;
      req_client_id      <= s.id;
      req_client_timeout <= s.tmo;
      req_time_stamp     <= s.now;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      predict_watchdog(s.op, s.id, s.tmo, s.now);
      if (s.typed)
         awaited_rsp.push_back(s.want);
      else
         foreach (step_rsp[i]) awaited_rsp.push_back(step_rsp[i]);
      if (!no_idle && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // all results in, then let the sequencer finish any ignored request
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_watchdog(input logic [TIME_W-1:0] en_word,
                                   input logic [TIME_W-1:0] gto_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_wdata <= en_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wd_on = en_word[0];
      csr_index <= CSR_GTIMEOUT;
      csr_wdata <= gto_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wd_gto = gto_word;
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         hold_left    <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 31);
      end
   end

   always @(posedge clock) begin : rsp_check
      wd_rsp_t got;
      wd_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind    = kind_type'(rsp_result_kind);
         got.id      = rsp_reported_id;
         got.matched = rsp_kick_matched;
         got.dur     = rsp_timeout_duration;
         got.expired = rsp_all_expired;
         got.least   = rsp_least_elapsed;
         got.last    = rsp_last_result;
         if (awaited_rsp.size() == 0) begin
            log_mismatch($sformatf("result %h with none outstanding", got));
         end else begin
            want = awaited_rsp.pop_front();
            if (got !== want)
               log_mismatch($sformatf("result %h, expected %h", got, want));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      step_t             s;
      logic [TIME_W-1:0] now_ms;
      int                pick;

      // empty table, watchdog off
      directed_steps.push_back(req_t(OP_CHECK, 8'h00, '0, '0,
                                     KIND_SUMMARY, 8'h00, 1'b0, 1'b1, '0));
      directed_steps.push_back(req_t(OP_KICK, 8'h5a, 32'h0, 32'd100,
                                     KIND_KICK, 8'h5a, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h00, 32'h0, 32'h0,
                                     KIND_REGISTERED, 8'h00, 1'b0, 1'b0, '0));
      // one entry, elapsed of all ones is a genuine minimum
      directed_steps.push_back(req_t(OP_CHECK, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                                     KIND_SUMMARY, 8'h00, 1'b0, 1'b1, 32'hffff_ffff));
      directed_steps.push_back(req_t(OP_REGISTER, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                                     KIND_REGISTERED, 8'hff, 1'b0, 1'b0, '0));
      directed_steps.push_back(req(OP_UNUSED, 8'haa, 32'h5555_5555, 32'h0000_1234));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'h10));
      directed_steps.push_back(req_t(OP_KICK, 8'hff, 32'h0, 32'h20,
                                     KIND_KICK, 8'hff, 1'b0, 1'b0, '0));
      directed_steps.push_back(csr_step(32'd1, 32'd1234));
      directed_steps.push_back(req_t(OP_KICK, 8'hff, 32'h0, 32'h20,
                                     KIND_KICK, 8'hff, 1'b1, 1'b0, '0));
      directed_steps.push_back(req_t(OP_KICK, 8'h77, 32'h0, 32'h30,
                                     KIND_KICK, 8'h77, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h03, 32'd100, 32'd1000,
                                     KIND_REGISTERED, 8'h03, 1'b0, 1'b0, '0));
      // same id twice: kicks must land on the first one
      directed_steps.push_back(req_t(OP_REGISTER, 8'h03, 32'd50, 32'd1000,
                                     KIND_REGISTERED, 8'h03, 1'b0, 1'b0, '0));
      // elapsed equal to timeout still counts as alive
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'd1100));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h09, 32'd2000, 32'd1200,
                                     KIND_REGISTERED, 8'h09, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h0a, 32'd500, 32'd1300,
                                     KIND_REGISTERED, 8'h0a, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h0b, 32'h8000_0000, 32'd1400,
                                     KIND_REGISTERED, 8'h0b, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h0c, 32'd1, 32'd1500,
                                     KIND_REGISTERED, 8'h0c, 1'b0, 1'b0, '0));
      directed_steps.push_back(req_t(OP_REGISTER, 8'h0d, 32'd7, 32'd1600,
                                     KIND_FULL, 8'h0d, 1'b0, 1'b0, '0));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'd1550));
      directed_steps.push_back(req_t(OP_KICK, 8'h03, 32'h0, 32'd1560,
                                     KIND_KICK, 8'h03, 1'b1, 1'b0, '0));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'd1700));
      directed_steps.push_back(csr_step(32'd1, 32'hffff_ffff));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'h8000_1000));
      directed_steps.push_back(csr_step(32'd1, 32'h0));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'h0000_0100));
      directed_steps.push_back(csr_step(32'd0, 32'h0));
      directed_steps.push_back(req(OP_CHECK, 8'h00, 32'h0, 32'd1700));
      directed_steps.push_back(req_t(OP_KICK, 8'h03, 32'h0, 32'd1800,
                                     KIND_KICK, 8'h03, 1'b0, 1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[n]) begin
         if (directed_steps[n].is_csr) begin
            wait_idle();
            program_watchdog(directed_steps[n].csr_en, directed_steps[n].csr_gto);
         end else begin
            send_request(directed_steps[n]);
         end
      end

      now_ms = 32'd1800;
      for (int round = 0; round < 4; round++) begin
         wait_idle();
         case (round)
            0: program_watchdog({31'($urandom), 1'b1}, $urandom_range(0, 9999));
            1: program_watchdog({31'($urandom), 1'b1}, 32'hffff_ffff);
            2: program_watchdog({31'($urandom), 1'b0}, 32'h0);
            default: program_watchdog(32'd1, $urandom);
         endcase
         no_idle <= (round == 0);
         // long receiver hold-off while requests keep coming
         if (round == 1)
            holds_asked <= holds_asked + 1;
         for (int k = 0; k < ROUND_ITEMS; k++) begin
            if ($urandom_range(0, 9) == 0)
               now_ms = now_ms + $urandom;
            else
               now_ms = now_ms + $urandom_range(0, 400);
            pick = $urandom_range(0, 99);
            if (pick < 40)
               s = req(OP_CHECK, ID_W'($urandom), $urandom, now_ms);
            else if (pick < 77 && ent_n > 0)
               s = req(OP_KICK, ent_id[$urandom_range(0, ent_n - 1)], $urandom, now_ms);
            else if (pick < 85)
               s = req(OP_KICK, ID_W'($urandom), $urandom, now_ms);
            else if (pick < 95)
               s = req(OP_REGISTER, ID_W'($urandom), $urandom, now_ms);
            else
               s = req(OP_UNUSED, ID_W'($urandom), $urandom, now_ms);
            send_request(s);
         end
      end
      wait_idle();

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
